[src/mbsp_pkg.sv]
// ----------------------------------------------------------------------------
// mbsp_pkg
// Shared types, codes and helpers for the MIDI byte stream parser.
// ----------------------------------------------------------------------------
package mbsp_pkg;

   // status byte codes
   parameter logic [7:0] RT_FIRST    = 8'hF8;
   parameter logic [7:0] SYSEX_START = 8'hF0;
   parameter logic [7:0] SYSEX_END   = 8'hF7;
   parameter logic [3:0] SYS_NIBBLE  = 4'hF;

   // reserved system statuses, indexed by low nibble
   parameter logic [15:0] RES_TABLE = 16'h2230;

   // result kinds
   typedef enum logic [1:0] {
      KIND_MSG    = 2'd0,
      KIND_RT     = 2'd1,
      KIND_ORPHAN = 2'd2
   } kind_type;

   // parser state, one-hot
   typedef enum logic [3:0] {
      PS_READY   = 4'b0001,
      PS_INMSG   = 4'b0010,
      PS_INSYSEX = 4'b0100,
      PS_INRES   = 4'b1000
   } parse_state_type;

   // one result transaction plus its valid flag
   typedef struct packed {
      logic       valid;
      kind_type   kind;
      logic [7:0] status_byte;
      logic [6:0] first_data;
      logic [6:0] second_data;
      logic [1:0] byte_count;
   } result_type;

   // message length including status; zero when no fixed length
   function automatic logic [1:0] msg_len(input logic [7:0] s);
      logic [1:0] n;
      n = 2'd0;
      if (s[7]) begin
         if (s[7:4] != SYS_NIBBLE) begin
            n = (s[7:4] == 4'hC || s[7:4] == 4'hD) ? 2'd2 : 2'd3;
         end else begin
            case (s[3:0])
               4'h1:    n = 2'd2;
               4'h2:    n = 2'd3;
               4'h3:    n = 2'd2;
               4'h6:    n = 2'd1;
               default: n = 2'd0;
            endcase
         end
      end
      return n;
   endfunction

endpackage

[src/mbsp_if.sv]
// ----------------------------------------------------------------------------
// mbsp channel interfaces
// Valid/ready channels for received bytes and parsed results.
// ----------------------------------------------------------------------------

// received byte channel
interface mbsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// parsed result channel
interface mbsp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] status_byte;
   logic [6:0] first_data;
   logic [6:0] second_data;
   logic [1:0] byte_count;

   modport source (output valid, output kind, output status_byte, output first_data,
                   output second_data, output byte_count, input ready);
   modport sink   (input valid, input kind, input status_byte, input first_data,
                   input second_data, input byte_count, output ready);
endinterface

[src/mbsp_step.sv]
// ----------------------------------------------------------------------------
// mbsp_step
// Parse state registers and the combinational per-byte update.
// ----------------------------------------------------------------------------
module mbsp_step (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic [7:0]            rx_byte,
   output mbsp_pkg::result_type  result
);

   mbsp_pkg::parse_state_type state_ff, state_in;
   logic       rv_ff, rv_in;
   logic [7:0] saved_ff, saved_in;
   logic [7:0] active_ff, active_in;
   logic [6:0] held0_ff, held0_in;
   logic [6:0] held1_ff, held1_in;
   logic [1:0] fill_ff, fill_in;

   logic       take;
   logic       chk;
   logic [1:0] len;

   // reserved status lookup
   function automatic logic RES_BIT(input logic [3:0] idx);
      return mbsp_pkg::RES_TABLE[idx];
   endfunction

   // next state and result
   always_comb begin
      state_in  = state_ff;
      rv_in     = rv_ff;
      saved_in  = saved_ff;
      active_in = active_ff;
      held0_in  = held0_ff;
      held1_in  = held1_ff;
      fill_in   = fill_ff;
      take      = 1'b0;
      chk       = 1'b0;
      len       = 2'd0;
      result    = '0;
      result.kind = mbsp_pkg::KIND_MSG;

      if (fire) begin
         if (rx_byte >= mbsp_pkg::RT_FIRST) begin
            // real-time byte passes straight through
            result.valid       = 1'b1;
            result.kind        = mbsp_pkg::KIND_RT;
            result.status_byte = rx_byte;
            result.byte_count  = 2'd1;
         end else begin
            unique case (state_ff)
               mbsp_pkg::PS_INSYSEX: begin
                  if (rx_byte == mbsp_pkg::SYSEX_END) state_in = mbsp_pkg::PS_READY;
               end
               mbsp_pkg::PS_INRES: begin
                  take = rx_byte[7];
               end
               mbsp_pkg::PS_INMSG: begin
                  if (rx_byte[7]) begin
                     take = 1'b1;
                  end else begin
                     chk = 1'b1;
                     if (fill_ff == 2'd1) begin
                        held0_in = rx_byte[6:0];
                        fill_in  = 2'd2;
                     end else if (fill_ff == 2'd2) begin
                        held1_in = rx_byte[6:0];
                        fill_in  = 2'd3;
                     end
                  end
               end
               mbsp_pkg::PS_READY: begin
                  if (rx_byte[7]) begin
                     take = 1'b1;
                  end else if (!rv_ff) begin
                     // data byte with no running status
                     result.valid      = 1'b1;
                     result.kind       = mbsp_pkg::KIND_ORPHAN;
                     result.first_data = rx_byte[6:0];
                     result.byte_count = 2'd1;
                  end else begin
                     // running status reuse
                     active_in = saved_ff;
                     held0_in  = rx_byte[6:0];
                     fill_in   = 2'd2;
                     state_in  = mbsp_pkg::PS_INMSG;
                     chk       = 1'b1;
                  end
               end
               default: ;
            endcase

            // status byte handling
            if (take) begin
               state_in = mbsp_pkg::PS_READY;
               fill_in  = 2'd0;
               if (rx_byte == mbsp_pkg::SYSEX_START) begin
                  saved_in  = rx_byte;
                  active_in = rx_byte;
                  rv_in     = 1'b0;
                  state_in  = mbsp_pkg::PS_INSYSEX;
               end else if (rx_byte != mbsp_pkg::SYSEX_END) begin
                  saved_in  = rx_byte;
                  active_in = rx_byte;
                  rv_in     = (rx_byte[7:4] != mbsp_pkg::SYS_NIBBLE);
                  if (rx_byte[7:4] == mbsp_pkg::SYS_NIBBLE && RES_BIT(rx_byte[3:0])) begin
                     state_in = mbsp_pkg::PS_INRES;
                  end else begin
                     state_in = mbsp_pkg::PS_INMSG;
                     fill_in  = 2'd1;
                     chk      = 1'b1;
                  end
               end
            end

            // message completion
            len = mbsp_pkg::msg_len(active_in);
            if (chk && len != 2'd0 && fill_in >= len) begin
               result.valid       = 1'b1;
               result.kind        = mbsp_pkg::KIND_MSG;
               result.status_byte = active_in;
               result.first_data  = (fill_in >= 2'd2) ? held0_in : 7'd0;
               result.second_data = (fill_in >= 2'd3) ? held1_in : 7'd0;
               result.byte_count  = fill_in;
               state_in           = mbsp_pkg::PS_READY;
               fill_in            = 2'd0;
            end
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= mbsp_pkg::PS_READY;
         rv_ff     <= 1'b0;
         saved_ff  <= 8'd0;
         active_ff <= 8'd0;
         held0_ff  <= 7'd0;
         held1_ff  <= 7'd0;
         fill_ff   <= 2'd0;
      end else begin
         state_ff  <= state_in;
         rv_ff     <= rv_in;
         saved_ff  <= saved_in;
         active_ff <= active_in;
         held0_ff  <= held0_in;
         held1_ff  <= held1_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

[src/midi_byte_stream_parser_core.sv]
// ----------------------------------------------------------------------------
// midi_byte_stream_parser_core
// MIDI byte stream parser with running status, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
// The parser takes one received MIDI byte per cycle while its results are
// taken, and gives at most one result per byte: a complete message, a
// real-time byte passed through, or an orphan data byte error. A byte lands
// in an input register, the parse state is updated from it combinationally,
// and any result is held in an output register until it is taken, so each
// result passes the input register and then the output register. The state
// update sets the rate; while a result waits to be taken the input register
// holds at most one more byte and the input then stalls.
module midi_byte_stream_parser_core (
   input logic            clock,
   input logic            reset,
   mbsp_req_if.sink       req_chan,
   mbsp_rsp_if.source     rsp_chan
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff, in_byte_in;
   logic                 out_valid_ff, out_valid_in;
   mbsp_pkg::result_type out_ff, out_in;

   logic                 advance;
   logic                 req_fire;
   mbsp_pkg::result_type step_res;

   // handshake control
   assign advance          = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready   = !in_valid_ff || advance;
   assign req_fire         = req_chan.valid && req_chan.ready;

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_chan.rx_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   mbsp_step u_step (
      .clock   (clock),
      .reset   (reset),
      .fire    (advance),
      .rx_byte (in_byte_ff),
      .result  (step_res)
   );

   // output register
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_in       = out_ff;
      if (advance && step_res.valid) begin
         out_valid_in = 1'b1;
         out_in       = step_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   // result transaction
   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.kind        = out_ff.kind;
   assign rsp_chan.status_byte = out_ff.status_byte;
   assign rsp_chan.first_data  = out_ff.first_data;
   assign rsp_chan.second_data = out_ff.second_data;
   assign rsp_chan.byte_count  = out_ff.byte_count;

   // real-time results carry a real-time status and length one
   a_rt_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.kind == mbsp_pkg::KIND_RT |->
         rsp_chan.status_byte >= mbsp_pkg::RT_FIRST && rsp_chan.byte_count == 2'd1)
      else $error("real-time result malformed");

   // orphan results carry no status and length one
   a_orphan_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.kind == mbsp_pkg::KIND_ORPHAN |->
         rsp_chan.status_byte == 8'd0 && rsp_chan.byte_count == 2'd1 &&
         rsp_chan.second_data == 7'd0)
      else $error("orphan result malformed");

   // complete messages have a status byte and match its length
   a_msg_len: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.kind == mbsp_pkg::KIND_MSG |->
         rsp_chan.status_byte[7] &&
         rsp_chan.byte_count == mbsp_pkg::msg_len(rsp_chan.status_byte))
      else $error("message length mismatch");

   // a held byte stays unchanged in the input register until it advances
   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("held byte lost");

endmodule
